FILE: src/bitonic_array_search_defines.svh
// Assertion macros for the bitonic array search block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BITONIC_ARRAY_SEARCH_DEFINES_SVH
`define BITONIC_ARRAY_SEARCH_DEFINES_SVH

// same-cycle implication
`define BAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitonic_array_search: same-cycle check failed");

// next-cycle implication
`define BAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitonic_array_search: next-cycle check failed");

`endif

FILE: src/bas_pkg.sv
// Package for the bitonic array search block: sizes, command codes and
// controller states. No dependencies.
`default_nettype none

package bas_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = AW + 1;
  localparam int unsigned DW     = 32;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned OUT_W  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PK_ADDR,
    ST_PK_A,
    ST_PK_B,
    ST_RS_ADDR,
    ST_RS_CMP,
    ST_FS_ADDR,
    ST_FS_CMP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: src/bas_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Used by bitonic_array_search as the element store. No dependencies.
`default_nettype none

module bas_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/bitonic_array_search.sv
// Bitonic array search: element store, peak search and two binary searches.
// Depends on bas_pkg, bas_ram and bitonic_array_search_defines.svh.
//
// Usage:
//   Slave stream: s_axis_tuser_i carries the command (start, append, query),
//   s_axis_tdata_i the signed value. Loads give no result; appends beyond
//   DEPTH are dropped and set the overflow flag.
//   A query gives one master-stream transaction with both hit flags, their
//   1-based positions and the overflow flag.
//   A query runs a peak search on the first query after a load (two reads of
//   the element store per probe), then a binary search for the key on the
//   rising side and one on the falling side (one read of the element store
//   per probe), then loads the output register. One query is in work at a
//   time; the element store has a single read port.
//   A finished result sits in the output register while the next transaction
//   is accepted; if the receiver stalls with a result still held, a new query
//   waits at its end until the register frees.
//   Reset clears the count, the peak and the overflow flag; the element store
//   is not cleared and only written entries are ever read.
`default_nettype none

`include "bitonic_array_search_defines.svh"

module bitonic_array_search
  import bas_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [DW-1:0]    s_axis_tdata_i,   // [31:0] value
  input  wire logic [CMD_W-1:0] s_axis_tuser_i,   // [1:0] command
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // [0] found_rising, [11:1] position_rising, [12] found_falling,
  // [23:13] position_falling, [24] overflowed, [31:25] zero
  output logic      [OUT_W-1:0] m_axis_tdata_o
);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     peak_q, peak_d;
  logic              peak_known_q, peak_known_d;
  logic              ovf_q, ovf_d;
  logic [CW-1:0]     lo_q, lo_d;
  logic [CW-1:0]     hip1_q, hip1_d;
  logic [AW-1:0]     mid_q, mid_d;
  logic [DW-1:0]     a_q, a_d;
  logic [DW-1:0]     key_q, key_d;
  logic              rf_q, rf_d;
  logic [POS_W-1:0]  rp_q, rp_d;
  logic              ff_q, ff_d;
  logic [POS_W-1:0]  fp_q, fp_d;
  logic              m_valid_q, m_valid_d;
  logic [OUT_W-1:0]  m_data_q, m_data_d;

  logic              s_acc;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DW-1:0]     mem_rdata;
  logic [CW:0]       mid_sum;
  logic [AW-1:0]     mid_c;
  logic [CW-1:0]     mid_p1;
  logic [CW-1:0]     peak_p1;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // midpoint of [lo, hip1 - 1]; only used while lo < hip1
  assign mid_sum = {1'b0, lo_q} + {1'b0, hip1_q} - (CW+1)'(1);
  assign mid_c   = mid_sum[AW:1];
  assign mid_p1  = {1'b0, mid_q} + CW'(1);
  assign peak_p1 = {1'b0, peak_q} + CW'(1);

  bas_ram #(
    .DATA_W (DW),
    .ADDR_W (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    peak_d       = peak_q;
    peak_known_d = peak_known_q;
    ovf_d        = ovf_q;
    lo_d         = lo_q;
    hip1_d       = hip1_q;
    mid_d        = mid_q;
    a_d          = a_q;
    key_d        = key_q;
    rf_d         = rf_q;
    rp_d         = rp_q;
    ff_d         = ff_q;
    fp_d         = fp_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    m_data_d     = m_data_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[AW-1:0];
    mem_re       = 1'b0;
    mem_raddr    = mid_c;

    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          if (s_axis_tuser_i == CMD_START) begin
            mem_we       = 1'b1;
            mem_waddr    = '0;
            count_d      = CW'(1);
            ovf_d        = 1'b0;
            peak_known_d = 1'b0;
          end else if (s_axis_tuser_i == CMD_APPEND) begin
            peak_known_d = 1'b0;
            if (count_q < CW'(DEPTH)) begin
              mem_we  = 1'b1;
              count_d = count_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end else if (s_axis_tuser_i == CMD_QUERY) begin
            key_d = s_axis_tdata_i;
            rf_d  = 1'b0;
            rp_d  = '0;
            ff_d  = 1'b0;
            fp_d  = '0;
            lo_d  = '0;
            if (count_q == '0) begin
              state_d = ST_DONE;
            end else if (peak_known_q) begin
              hip1_d  = peak_p1;
              state_d = ST_RS_ADDR;
            end else begin
              hip1_d  = count_q;
              peak_d  = '0;
              state_d = ST_PK_ADDR;
            end
          end
        end
      end
      ST_PK_ADDR: begin
        if (lo_q < hip1_q) begin
          mid_d = mid_c;
          if ({1'b0, mid_c} == count_q - CW'(1)) begin
            peak_d = mid_c;
            hip1_d = {1'b0, mid_c};
          end else begin
            mem_re  = 1'b1;
            state_d = ST_PK_A;
          end
        end else begin
          peak_known_d = 1'b1;
          lo_d         = '0;
          hip1_d       = peak_p1;
          state_d      = ST_RS_ADDR;
        end
      end
      ST_PK_A: begin
        a_d       = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = mid_p1[AW-1:0];
        state_d   = ST_PK_B;
      end
      ST_PK_B: begin
        if ($signed(a_q) > $signed(mem_rdata)) begin
          peak_d = mid_q;
          hip1_d = {1'b0, mid_q};
        end else begin
          lo_d = mid_p1;
        end
        state_d = ST_PK_ADDR;
      end
      ST_RS_ADDR: begin
        if (lo_q < hip1_q) begin
          mid_d   = mid_c;
          mem_re  = 1'b1;
          state_d = ST_RS_CMP;
        end else begin
          lo_d    = peak_p1;
          hip1_d  = count_q;
          state_d = ST_FS_ADDR;
        end
      end
      ST_RS_CMP: begin
        if (mem_rdata == key_q) begin
          rf_d    = 1'b1;
          rp_d    = POS_W'(mid_p1);
          lo_d    = peak_p1;
          hip1_d  = count_q;
          state_d = ST_FS_ADDR;
        end else begin
          if ($signed(mem_rdata) < $signed(key_q)) begin
            lo_d = mid_p1;
          end else begin
            hip1_d = {1'b0, mid_q};
          end
          state_d = ST_RS_ADDR;
        end
      end
      ST_FS_ADDR: begin
        if (lo_q < hip1_q) begin
          mid_d   = mid_c;
          mem_re  = 1'b1;
          state_d = ST_FS_CMP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_FS_CMP: begin
        if (mem_rdata == key_q) begin
          ff_d    = 1'b1;
          fp_d    = POS_W'(mid_p1);
          state_d = ST_DONE;
        end else begin
          if ($signed(mem_rdata) > $signed(key_q)) begin
            lo_d = mid_p1;
          end else begin
            hip1_d = {1'b0, mid_q};
          end
          state_d = ST_FS_ADDR;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_W'({ovf_q, fp_q, ff_q, rp_q, rf_q});
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      peak_q       <= '0;
      peak_known_q <= 1'b0;
      ovf_q        <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      peak_q       <= peak_d;
      peak_known_q <= peak_known_d;
      ovf_q        <= ovf_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hip1_q   <= hip1_d;
    mid_q    <= mid_d;
    a_q      <= a_d;
    key_q    <= key_d;
    rf_q     <= rf_d;
    rp_q     <= rp_d;
    ff_q     <= ff_d;
    fp_q     <= fp_d;
    m_data_q <= m_data_d;
  end

  `BAS_ASSERT_IMP(a_count_max, 1'b1, count_q <= CW'(DEPTH))
  `BAS_ASSERT_IMP(a_write_room, mem_we, (s_axis_tuser_i == CMD_START) || (count_q < CW'(DEPTH)))
  `BAS_ASSERT_NXT(a_query_busy, s_acc && (s_axis_tuser_i == CMD_QUERY), state_q != ST_IDLE)
  `BAS_ASSERT_IMP(a_peak_set, $rose(peak_known_q), $past(state_q == ST_PK_ADDR))
  `BAS_ASSERT_IMP(a_hit_pos, m_valid_q && m_data_q[0], m_data_q[POS_W:1] != '0)

endmodule

`default_nettype wire
